>>> sv/i2crts_pkg.sv
// Shared types, codes and constants for the I2C register transaction sequencer.
package i2crts_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;

	localparam logic [7:0] MAX_LEN  = 8'd255;
	localparam logic [7:0] ONE_BYTE = 8'h01;

	localparam int unsigned RES_SLOTS = 4;
	localparam int unsigned CNT_W     = 3;

	typedef enum logic [10:0] {
		PH_W_START  = 11'b000_0000_0001,
		PH_W_ADDR   = 11'b000_0000_0010,
		PH_W_REG    = 11'b000_0000_0100,
		PH_W_DATA   = 11'b000_0000_1000,
		PH_R_START  = 11'b000_0001_0000,
		PH_R_ADDR   = 11'b000_0010_0000,
		PH_R_REG    = 11'b000_0100_0000,
		PH_R_RSTART = 11'b000_1000_0000,
		PH_R_ADDR2  = 11'b001_0000_0000,
		PH_R_DATA   = 11'b010_0000_0000,
		PH_IDLE     = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [6:0]  target_addr;
		logic [7:0]  register_addr;
		logic [7:0]  total_bytes;
		logic [7:0]  bytes_done;
	} seq_state_t;

	typedef struct packed {
		logic        send_start;
		logic        send_stop;
		logic        dr_write;
		logic [7:0]  dr_value;
		logic        rx_valid;
		logic [7:0]  rx_value;
		logic        done_res;
	} res_t;

	function automatic res_t mk_res(logic st, logic sp, logic dw, logic [7:0] dv,
		logic rv, logic [7:0] rx, logic dn);
		res_t r;
		r.send_start = st;
		r.send_stop  = sp;
		r.dr_write   = dw;
		r.dr_value   = dw ? dv : 8'd0;
		r.rx_valid   = rv;
		r.rx_value   = rv ? rx : 8'd0;
		r.done_res   = dn;
		return r;
	endfunction

endpackage

>>> sv/i2crts_step.sv
// Next-state and result logic for one registered input item.
module i2crts_step import i2crts_pkg::*; (
	input  logic [1:0]             operation,
	input  logic [6:0]             device_addr,
	input  logic [7:0]             reg_addr,
	input  logic [7:0]             byte_count,
	input  logic                   start_sent,
	input  logic                   addr_sent,
	input  logic                   tx_empty,
	input  logic                   rx_full,
	input  logic [7:0]             next_tx_byte,
	input  logic [7:0]             rx_byte,
	input  seq_state_t             cur,
	output seq_state_t             nxt,
	output res_t [RES_SLOTS-1:0]   res,
	output logic [CNT_W-1:0]       num
);

	logic [7:0] cnt;
	logic [7:0] abyte;
	logic [7:0] bd_inc;

	always_comb begin
		nxt    = cur;
		res    = '0;
		num    = '0;
		cnt    = byte_count;
		abyte  = {cur.target_addr, 1'b0};
		bd_inc = '0;
		if (operation == OP_WRITE || operation == OP_READ) begin
			if (cnt == 8'd0) begin
				cnt = ONE_BYTE;
			end
			if (cnt > MAX_LEN) begin
				cnt = MAX_LEN;
			end
			nxt.target_addr   = device_addr;
			nxt.register_addr = reg_addr;
			nxt.total_bytes   = cnt;
			nxt.bytes_done    = '0;
			nxt.phase         = (operation == OP_WRITE) ? PH_W_START : PH_R_START;
			res[0]            = mk_res(1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
			num               = CNT_W'(1);
		end else if (operation == OP_EVENT) begin
			if (start_sent) begin
				case (nxt.phase)
					PH_R_START: begin
						res[num[1:0]] = mk_res(1'b0, 1'b0, 1'b1, abyte, 1'b0, 8'd0, 1'b0);
						num = num + CNT_W'(1);
						nxt.phase = PH_R_ADDR;
					end
					PH_R_RSTART: begin
						res[num[1:0]] = mk_res(1'b0, 1'b0, 1'b1, abyte | ONE_BYTE, 1'b0, 8'd0,
							1'b0);
						num = num + CNT_W'(1);
						nxt.phase = PH_R_ADDR2;
					end
					PH_W_START: begin
						res[num[1:0]] = mk_res(1'b0, 1'b0, 1'b1, abyte, 1'b0, 8'd0, 1'b0);
						num = num + CNT_W'(1);
						nxt.phase = PH_W_ADDR;
					end
					default: begin
					end
				endcase
			end
			if (addr_sent) begin
				case (nxt.phase)
					PH_R_ADDR: begin
						res[num[1:0]] = mk_res(1'b0, 1'b0, 1'b1, cur.register_addr, 1'b0, 8'd0,
							1'b0);
						num = num + CNT_W'(1);
						nxt.phase = PH_R_REG;
					end
					PH_R_ADDR2: begin
						nxt.phase = PH_R_DATA;
						if (cur.total_bytes == ONE_BYTE) begin
							res[num[1:0]] = mk_res(1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
							num = num + CNT_W'(1);
						end
					end
					PH_W_ADDR: begin
						res[num[1:0]] = mk_res(1'b0, 1'b0, 1'b1, cur.register_addr, 1'b0, 8'd0,
							1'b0);
						num = num + CNT_W'(1);
						nxt.phase = PH_W_REG;
					end
					default: begin
					end
				endcase
			end
			if (tx_empty) begin
				case (nxt.phase)
					PH_R_REG: begin
						res[num[1:0]] = mk_res(1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
						num = num + CNT_W'(1);
						nxt.phase = PH_R_RSTART;
					end
					PH_W_REG: begin
						bd_inc = nxt.bytes_done + 8'd1;
						nxt.bytes_done = bd_inc;
						if (bd_inc >= cur.total_bytes) begin
							res[num[1:0]] = mk_res(1'b0, 1'b1, 1'b1, next_tx_byte, 1'b0, 8'd0,
								1'b1);
							nxt.phase = PH_IDLE;
						end else begin
							res[num[1:0]] = mk_res(1'b0, 1'b0, 1'b1, next_tx_byte, 1'b0, 8'd0,
								1'b0);
						end
						num = num + CNT_W'(1);
					end
					default: begin
					end
				endcase
			end
			if (rx_full && nxt.phase == PH_R_DATA) begin
				bd_inc = nxt.bytes_done + 8'd1;
				nxt.bytes_done = bd_inc;
				if (bd_inc >= cur.total_bytes) begin
					res[num[1:0]] = mk_res(1'b0, cur.total_bytes > ONE_BYTE, 1'b0, 8'd0, 1'b1,
						rx_byte, 1'b1);
					nxt.phase = PH_IDLE;
				end else begin
					res[num[1:0]] = mk_res(1'b0, 1'b0, 1'b0, 8'd0, 1'b1, rx_byte, 1'b0);
				end
				num = num + CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/i2c_register_transaction_sequencer.sv
// Top level of the I2C master register read/write transaction sequencer.
// Each transfer in is held in an input register until the result buffer can take it; there
// the sequencing logic updates the transaction state and produces up to four actions. These
// load a four-slot result buffer that shows one action per cycle while out_stall is low,
// with last marking the final one. An item that causes k actions (k from 0 to 4) holds the
// buffer until all k are taken, so items with at most one action each go through at one per
// cycle when the output does not stall. Items that cause no action only update state.
module i2c_register_transaction_sequencer import i2crts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [6:0] device_addr,
	input  logic [7:0] reg_addr,
	input  logic [7:0] byte_count,
	input  logic       start_sent,
	input  logic       addr_sent,
	input  logic       tx_empty,
	input  logic       rx_full,
	input  logic [7:0] next_tx_byte,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       send_start,
	output logic       send_stop,
	output logic       dr_write,
	output logic [7:0] dr_value,
	output logic       rx_valid,
	output logic [7:0] rx_value,
	output logic       done_res,
	output logic       last
);

	logic                  valid_s1;
	logic [1:0]            operation_s1;
	logic [6:0]            device_addr_s1;
	logic [7:0]            reg_addr_s1;
	logic [7:0]            byte_count_s1;
	logic                  start_sent_s1;
	logic                  addr_sent_s1;
	logic                  tx_empty_s1;
	logic                  rx_full_s1;
	logic [7:0]            next_tx_byte_s1;
	logic [7:0]            rx_byte_s1;

	seq_state_t            state_q;
	seq_state_t            state_nxt;
	res_t [RES_SLOTS-1:0]  step_res;
	logic [CNT_W-1:0]      step_num;

	res_t [RES_SLOTS-1:0]  res_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  take;
	logic                  buf_free;
	logic                  advance;
	logic                  load_s1;

	i2crts_step u_step (
		.operation    (operation_s1),
		.device_addr  (device_addr_s1),
		.reg_addr     (reg_addr_s1),
		.byte_count   (byte_count_s1),
		.start_sent   (start_sent_s1),
		.addr_sent    (addr_sent_s1),
		.tx_empty     (tx_empty_s1),
		.rx_full      (rx_full_s1),
		.next_tx_byte (next_tx_byte_s1),
		.rx_byte      (rx_byte_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (step_res),
		.num          (step_num)
	);

	assign out_valid = (cnt_q != '0);
	assign take      = out_valid && !out_stall;
	assign buf_free  = (cnt_q == '0) || (cnt_q == CNT_W'(1) && !out_stall);
	assign advance   = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;
	assign load_s1   = in_valid && !in_stall;

	assign send_start = res_q[0].send_start;
	assign send_stop  = res_q[0].send_stop;
	assign dr_write   = res_q[0].dr_write;
	assign dr_value   = res_q[0].dr_value;
	assign rx_valid   = res_q[0].rx_valid;
	assign rx_value   = res_q[0].rx_value;
	assign done_res   = res_q[0].done_res;
	assign last       = (cnt_q == CNT_W'(1));

	// hold the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			operation_s1    <= operation;
			device_addr_s1  <= device_addr;
			reg_addr_s1     <= reg_addr;
			byte_count_s1   <= byte_count;
			start_sent_s1   <= start_sent;
			addr_sent_s1    <= addr_sent;
			tx_empty_s1     <= tx_empty;
			rx_full_s1      <= rx_full;
			next_tx_byte_s1 <= next_tx_byte;
			rx_byte_s1      <= rx_byte;
		end
	end

	// advance the transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_R_START;
			state_q.target_addr   <= '0;
			state_q.register_addr <= '0;
			state_q.total_bytes   <= '0;
			state_q.bytes_done    <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// load or drain the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance && step_num != '0) begin
			cnt_q <= step_num;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_num != '0) begin
			res_q <= step_res;
		end else if (take) begin
			for (int i = 0; i < RES_SLOTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

endmodule
